>>> sv/pur_pkg.sv
package pur_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int FRAC_BITS = 16;
   localparam int DATA_W = 32;
   localparam int POS_W = DATA_W + 1;
   localparam int T_W = FRAC_BITS + 1;
   localparam int NUM_W = DATA_W + FRAC_BITS;
   localparam int PROD_W = DATA_W + 1 + T_W + 1;
   localparam int CNT_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int TR_W = POS_W + CNT_W + 1;
   localparam int LANES = 3;
   localparam int CSR_ADDR_W = 3;
   localparam logic [DATA_W-1:0] STEP_RESET = DATA_W'(64'd1 << FRAC_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_MUL,
      ST_ADD
   } state_type;

endpackage

>>> sv/pur_req_if.sv
interface pur_req_if;
   logic                              valid;
   logic                              ready;
   logic                              first;
   logic        [pur_pkg::DATA_W-1:0] dist_req;
   logic signed [pur_pkg::DATA_W-1:0] px;
   logic signed [pur_pkg::DATA_W-1:0] py;
   logic signed [pur_pkg::DATA_W-1:0] pz;

   modport source (output valid, first, dist_req, px, py, pz, input ready);
   modport sink (input valid, first, dist_req, px, py, pz, output ready);
endinterface

>>> sv/pur_rsp_if.sv
interface pur_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pur_pkg::DATA_W-1:0] sx;
   logic signed [pur_pkg::DATA_W-1:0] sy;
   logic signed [pur_pkg::DATA_W-1:0] sz;
   logic                              last;
   logic                              truncated;

   modport source (output valid, sx, sy, sz, last, truncated, input ready);
   modport sink (input valid, sx, sy, sz, last, truncated, output ready);
endinterface

>>> sv/pur_div.sv
module pur_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pur_pkg::NUM_W-1:0]   dividend,
   input  logic [pur_pkg::DATA_W-1:0]  divisor,
   output logic [pur_pkg::NUM_W-1:0]   quotient,
   output logic [pur_pkg::DATA_W-1:0]  remainder,
   output logic                        busy
);

   localparam int CW = $clog2(pur_pkg::NUM_W + 1);

   logic                        busy_ff, busy_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [pur_pkg::NUM_W-1:0]   quo_ff, quo_in;
   logic [pur_pkg::DATA_W-1:0]  rem_ff, rem_in;
   logic [pur_pkg::DATA_W-1:0]  dvs_ff, dvs_in;
   logic [pur_pkg::DATA_W:0]    trial;
   logic                        fits;

   always_comb begin
      trial = {rem_ff, quo_ff[pur_pkg::NUM_W-1]};
      fits = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CW'(pur_pkg::NUM_W);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[pur_pkg::NUM_W-2:0], fits};
         rem_in = fits ? pur_pkg::DATA_W'(trial - {1'b0, dvs_ff})
                       : trial[pur_pkg::DATA_W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign remainder = rem_ff;
   assign busy = busy_ff;

endmodule

>>> sv/pur_lane.sv
module pur_lane (
   input  logic                               clock,
   input  logic                               load,
   input  logic signed [pur_pkg::DATA_W-1:0]  a,
   input  logic signed [pur_pkg::DATA_W-1:0]  b,
   input  logic        [pur_pkg::T_W-1:0]     t,
   output logic signed [pur_pkg::DATA_W-1:0]  y
);

   logic signed [pur_pkg::DATA_W:0]   diff;
   logic signed [pur_pkg::T_W:0]      t_s;
   logic signed [pur_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [pur_pkg::PROD_W-1:0] rounded;
   logic signed [pur_pkg::PROD_W-1:0] shifted;

   always_comb begin
      diff = (pur_pkg::DATA_W+1)'(b) - (pur_pkg::DATA_W+1)'(a);
      t_s = signed'({1'b0, t});
      prod_in = pur_pkg::PROD_W'(diff) * pur_pkg::PROD_W'(t_s);
      rounded = prod_ff + pur_pkg::PROD_W'(64'd1 << (pur_pkg::FRAC_BITS - 1));
      shifted = rounded >>> pur_pkg::FRAC_BITS;
      y = a + signed'(shifted[pur_pkg::DATA_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

endmodule

>>> sv/polyline_uniform_resampler_unit.sv
// Channel   Direction  Beat
// req_bus   in         one polyline vertex: first, dist_req, px, py, pz
// rsp_bus   out        one sample point: sx, sy, sz, last, truncated
// csr_*     in/out     APB-style access to sample_step at byte address 0
//
// A starting vertex is sent from PREP as a single last beat; a vertex whose
// segment holds no sample returns from PREP to IDLE. A segment with samples
// first runs the shared-width bit-serial dividers, then each sample passes
// through the multiply lanes and the output register, which a stalled beat holds.
// Synchronous reset clears the vertex history and sets sample_step to 1.0.
// A stalled result beat holds the engine; no new vertex is taken until the
// last beat of the current one is loaded.
module polyline_uniform_resampler_unit (
   input  logic                              clock,
   input  logic                              reset,
   pur_req_if.sink                           req_bus,
   pur_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pur_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pur_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [pur_pkg::DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready
);

   localparam int DW = pur_pkg::DATA_W;
   localparam int NW = pur_pkg::NUM_W;
   localparam int PW = pur_pkg::POS_W;
   localparam int CW = pur_pkg::CNT_W;
   localparam int LN = pur_pkg::LANES;

   pur_pkg::state_type state_ff, state_in;

   logic [DW-1:0]        step_ff, step_in;
   logic [DW-1:0]        prev_dist_ff, prev_dist_in;
   logic signed [DW-1:0] prev_pt_ff [LN];
   logic signed [DW-1:0] prev_pt_in [LN];
   logic [PW-1:0]        np_ff, np_in;
   logic                 active_ff, active_in;
   logic [DW-1:0]        d1_ff, d1_in;
   logic signed [DW-1:0] p1_ff [LN];
   logic signed [DW-1:0] p1_in [LN];
   logic                 first_ff, first_in;
   logic                 trunc_ff, trunc_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [NW-1:0]        q_ff, q_in, qs_ff, qs_in;
   logic [DW-1:0]        r_ff, r_in, rs_ff, rs_in, den_ff, den_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_pt_ff [LN];
   logic signed [DW-1:0] rsp_pt_in [LN];
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_trunc_ff, rsp_trunc_in;

   logic [DW-1:0]        step_eff;
   logic                 out_free;
   logic                 accept;
   logic                 div_start;
   logic                 mul_load;
   logic [NW-1:0]        quo_a, quo_b, quo_c;
   logic [DW-1:0]        rem_a, rem_b, rem_c;
   logic                 busy_a, busy_b, busy_c;
   logic [DW-1:0]        seg_len;
   logic [DW-1:0]        offset;
   logic [DW-1:0]        left;
   logic [pur_pkg::TR_W-1:0] span_end;
   logic [PW:0]          np_next;
   logic [DW:0]          r_sum;
   logic                 r_wrap;
   logic                 is_last;
   logic signed [DW-1:0] lane_y [LN];

   assign step_eff = (step_ff == '0) ? DW'(1) : step_ff;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == pur_pkg::ST_IDLE);

   assign seg_len = d1_ff - prev_dist_ff;
   assign offset = DW'(np_ff - {1'b0, prev_dist_ff});
   assign left = DW'({1'b0, d1_ff} - np_ff);
   assign span_end = pur_pkg::TR_W'(np_ff)
                   + pur_pkg::TR_W'(step_eff) * pur_pkg::TR_W'(pur_pkg::MAX_SAMPLES);
   assign np_next = {1'b0, np_ff} + (PW+1)'(step_eff);
   assign r_sum = {1'b0, r_ff} + {1'b0, rs_ff};
   assign r_wrap = r_sum >= {1'b0, den_ff};

   pur_div u_div_t (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend({offset, {pur_pkg::FRAC_BITS{1'b0}}}), .divisor(seg_len),
      .quotient(quo_a), .remainder(rem_a), .busy(busy_a)
   );

   pur_div u_div_step (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend({step_eff, {pur_pkg::FRAC_BITS{1'b0}}}), .divisor(seg_len),
      .quotient(quo_b), .remainder(rem_b), .busy(busy_b)
   );

   pur_div u_div_skip (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(NW'(left)), .divisor(step_eff),
      .quotient(quo_c), .remainder(rem_c), .busy(busy_c)
   );

   for (genvar i = 0; i < LN; i++) begin : g_lane
      pur_lane u_lane (
         .clock(clock), .load(mul_load), .a(prev_pt_ff[i]), .b(p1_ff[i]),
         .t(q_ff[pur_pkg::T_W-1:0]), .y(lane_y[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      prev_dist_in = prev_dist_ff;
      prev_pt_in = prev_pt_ff;
      np_in = np_ff;
      active_in = active_ff;
      d1_in = d1_ff;
      p1_in = p1_ff;
      first_in = first_ff;
      trunc_in = trunc_ff;
      cnt_in = cnt_ff;
      q_in = q_ff;
      qs_in = qs_ff;
      r_in = r_ff;
      rs_in = rs_ff;
      den_in = den_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pt_in = rsp_pt_ff;
      rsp_last_in = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;
      div_start = 1'b0;
      mul_load = 1'b0;
      is_last = 1'b0;

      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         step_in = csr_pwdata;
      end

      case (state_ff)
         pur_pkg::ST_IDLE: begin
            if (accept) begin
               first_in = req_bus.first;
               d1_in = req_bus.dist_req;
               p1_in[0] = req_bus.px;
               p1_in[1] = req_bus.py;
               p1_in[2] = req_bus.pz;
               state_in = pur_pkg::ST_PREP;
            end
         end
         pur_pkg::ST_PREP: begin
            if (first_ff || !active_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_pt_in = p1_ff;
                  rsp_last_in = 1'b1;
                  rsp_trunc_in = 1'b0;
                  np_in = {1'b0, d1_ff} + {1'b0, step_eff};
                  state_in = pur_pkg::ST_IDLE;
               end
            end else if (np_ff > {1'b0, d1_ff}) begin
               state_in = pur_pkg::ST_IDLE;
            end else begin
               trunc_in = span_end <= pur_pkg::TR_W'(d1_ff);
               cnt_in = '0;
               den_in = seg_len;
               div_start = 1'b1;
               state_in = pur_pkg::ST_DIV;
            end
         end
         pur_pkg::ST_DIV: begin
            if (!busy_a && !busy_b && !busy_c) begin
               q_in = quo_a;
               r_in = rem_a;
               qs_in = quo_b;
               rs_in = rem_b;
               state_in = pur_pkg::ST_MUL;
            end
         end
         pur_pkg::ST_MUL: begin
            mul_load = 1'b1;
            state_in = pur_pkg::ST_ADD;
         end
         pur_pkg::ST_ADD: begin
            is_last = trunc_ff ? (cnt_ff == CW'(pur_pkg::MAX_SAMPLES - 1))
                               : (np_next > (PW+1)'(d1_ff));
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pt_in = lane_y;
               rsp_last_in = is_last;
               rsp_trunc_in = trunc_ff;
               np_in = PW'(np_next);
               cnt_in = cnt_ff + CW'(1);
               q_in = q_ff + qs_ff + NW'(r_wrap);
               r_in = r_wrap ? DW'(r_sum - {1'b0, den_ff}) : r_sum[DW-1:0];
               if (is_last) begin
                  if (trunc_ff) begin
                     np_in = {1'b0, d1_ff} + {1'b0, step_eff} - {1'b0, rem_c};
                  end
                  state_in = pur_pkg::ST_IDLE;
               end else begin
                  state_in = pur_pkg::ST_MUL;
               end
            end
         end
         default: begin
            state_in = pur_pkg::ST_IDLE;
         end
      endcase

      if (state_ff != pur_pkg::ST_IDLE && state_in == pur_pkg::ST_IDLE) begin
         prev_dist_in = d1_ff;
         prev_pt_in = p1_ff;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pur_pkg::ST_IDLE;
         step_ff <= pur_pkg::STEP_RESET;
         prev_dist_ff <= '0;
         prev_pt_ff <= '{default: '0};
         np_ff <= '0;
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         prev_dist_ff <= prev_dist_in;
         prev_pt_ff <= prev_pt_in;
         np_ff <= np_in;
         active_ff <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d1_ff <= d1_in;
      p1_ff <= p1_in;
      first_ff <= first_in;
      trunc_ff <= trunc_in;
      cnt_ff <= cnt_in;
      q_ff <= q_in;
      qs_ff <= qs_in;
      r_ff <= r_in;
      rs_ff <= rs_in;
      den_ff <= den_in;
      rsp_pt_ff <= rsp_pt_in;
      rsp_last_ff <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.sx = rsp_pt_ff[0];
   assign rsp_bus.sy = rsp_pt_ff[1];
   assign rsp_bus.sz = rsp_pt_ff[2];
   assign rsp_bus.last = rsp_last_ff;
   assign rsp_bus.truncated = rsp_trunc_ff;

   assign csr_prdata = csr_paddr[2] ? '0 : step_ff;
   assign csr_pready = 1'b1;

   a_one_vertex: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_bus.ready)
      else $error("vertex accepted while another is in work");

   a_t_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pur_pkg::ST_MUL) |-> (q_ff <= NW'(64'd1 << pur_pkg::FRAC_BITS)))
      else $error("interpolation fraction above one");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pur_pkg::ST_MUL) |-> (np_ff <= {1'b0, d1_ff}))
      else $error("sample position beyond segment end");

   a_skip_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pur_pkg::ST_MUL) |->
         (trunc_ff == (quo_c >= NW'(pur_pkg::MAX_SAMPLES))))
      else $error("truncation flag disagrees with the sample count");

endmodule
